FILE: design/movt_pkg.sv
// shared types and constants for the object version table
`timescale 1ns / 1ps
`default_nettype none

package movt_pkg;

  localparam int ID_W  = 12;
  localparam int VER_W = 4;

  // ids at or above this bound cannot be addressed by the 12-bit field
  localparam int ID_SPACE = 1 << ID_W;

  localparam logic OP_READ = 1'b0;
  localparam logic OP_INCR = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ID_W-1:0]  object_id;
    logic [VER_W-1:0] ref_version;
  } req_item_t;

  typedef struct packed {
    logic             op_echo;
    logic [ID_W-1:0]  object_echo;
    logic [VER_W-1:0] version_out;
  } rsp_item_t;

  // classified request as handed from front to back
  typedef struct packed {
    logic             incr;
    logic [ID_W-1:0]  object_id;
    logic             id_ok;
    logic [VER_W-1:0] ref_mod;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

`default_nettype wire

FILE: design/modular_object_version_table_top.sv
// top level of the per-object modular version table
`timescale 1ns / 1ps
`default_nettype none

// keeps one version counter per object, each counting modulo VERSION_SLOTS;
// an increment request bumps the addressed counter (wrapping to zero) and
// returns the new value, a read request returns the counter minus the
// reference version modulo VERSION_SLOTS; every request yields one result
// that echoes the opcode and object id, only the low 4 bits of the counter
// are reported, and ids at or above OBJECT_COUNT read as zero and are never
// written; after reset a clearing pass zeroes the counter memory, one entry
// per cycle, over min(OBJECT_COUNT, 4096) entries, and full stays high
// during that time; after that each request passes through the back end in
// two steps (the registered memory read, then the update, memory write-back
// and result load), and the back end takes no new request until the last one
// has loaded its result; a two-entry queue lets requests be taken while the
// back end is busy or a result waits to be popped
module modular_object_version_table_top #(
  parameter int OBJECT_COUNT  = 4096,
  parameter int VERSION_SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  movt_pkg::req_item_t req,
  output logic                empty,
  input  logic                pop,
  output movt_pkg::rsp_item_t rsp
);
  import movt_pkg::*;

  cmd_t         front_cmd;
  cmd_t         q_head;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;
  back_status_t status;
  logic         rsp_valid;

  // no request transfers while the clearing pass runs
  assign full  = q_full || status.clearing;
  assign empty = !rsp_valid;

  // classify the request on the way in
  movt_front #(
    .OBJECT_COUNT  (OBJECT_COUNT),
    .VERSION_SLOTS (VERSION_SLOTS)
  ) u_front (
    .req (req),
    .cmd (front_cmd)
  );

  // decouples request intake from table updates
  movt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push && !full),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .empty   (q_empty)
  );

  // counter memory and result register
  movt_back #(
    .OBJECT_COUNT  (OBJECT_COUNT),
    .VERSION_SLOTS (VERSION_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .status    (status),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_pop   (pop && rsp_valid)
  );

endmodule

`default_nettype wire

FILE: design/movt_front.sv
// front end: range check of the object id and reduction of the reference version
`timescale 1ns / 1ps
`default_nettype none

module movt_front #(
  parameter int OBJECT_COUNT  = 4096,
  parameter int VERSION_SLOTS = 16
) (
  input  movt_pkg::req_item_t req,
  output movt_pkg::cmd_t      cmd
);
  import movt_pkg::*;

  localparam int CNT_W = 17;

  // reference versions are below 16, so the residue table is small
  logic [VER_W-1:0] ref_mod_tab [1 << VER_W];

  for (genvar i = 0; i < (1 << VER_W); i++) begin : g_ref_mod
    assign ref_mod_tab[i] = VER_W'(i % VERSION_SLOTS);
  end

  always_comb begin
    cmd.incr      = (req.opcode == OP_INCR);
    cmd.object_id = req.object_id;
    cmd.id_ok     = (CNT_W'(req.object_id) < CNT_W'(OBJECT_COUNT));
    cmd.ref_mod   = ref_mod_tab[req.ref_version];
  end

endmodule

`default_nettype wire

FILE: design/movt_queue.sv
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module movt_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  movt_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           rd_en,
  output movt_pkg::cmd_t rd_data,
  output logic           empty
);
  import movt_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = entries[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/movt_back.sv
// back end: counter memory, clearing pass, update and result register
`timescale 1ns / 1ps
`default_nettype none

module movt_back #(
  parameter int OBJECT_COUNT  = 4096,
  parameter int VERSION_SLOTS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  movt_pkg::cmd_t         q_head,
  input  logic                   q_empty,
  output logic                   q_pop,
  output movt_pkg::back_status_t status,
  output movt_pkg::rsp_item_t    rsp,
  output logic                   rsp_valid,
  input  logic                   rsp_pop
);
  import movt_pkg::*;

  localparam int DEPTH = (OBJECT_COUNT < ID_SPACE) ? OBJECT_COUNT : ID_SPACE;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CW    = $clog2(VERSION_SLOTS);

  logic [CW-1:0] table_mem [DEPTH];

  back_state_t state;
  back_state_t state_next;

  logic [IDX_W-1:0] clr_idx;
  logic             clr_last;
  cmd_t             cmd;
  logic [CW-1:0]    rd_data;
  logic             exec_fire;
  logic [CW-1:0]    cur;
  logic [CW-1:0]    ref_val;
  logic [CW-1:0]    incr_val;
  logic [CW:0]      diff_wide;
  logic [CW-1:0]    read_val;
  logic [CW-1:0]    result;

  assign clr_last = (clr_idx == IDX_W'(DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_CLEAR: begin
        if (clr_last) begin
          state_next = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          state_next = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (!rsp_valid || rsp_pop) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop           = 1'b0;
    exec_fire       = 1'b0;
    status.clearing = 1'b0;
    unique case (state)
      BK_CLEAR: status.clearing = 1'b1;
      BK_IDLE:  q_pop = !q_empty;
      BK_EXEC:  exec_fire = !rsp_valid || rsp_pop;
      default:  status.clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BK_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (exec_fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_pop) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // update arithmetic, out-of-range ids see a zero counter
  always_comb begin
    cur       = cmd.id_ok ? rd_data : '0;
    ref_val   = CW'(cmd.ref_mod);
    incr_val  = (cur == CW'(VERSION_SLOTS - 1)) ? '0 : cur + CW'(1);
    diff_wide = (cur >= ref_val)
              ? {1'b0, cur} - {1'b0, ref_val}
              : {1'b0, cur} + (CW + 1)'(VERSION_SLOTS) - {1'b0, ref_val};
    read_val  = diff_wide[CW-1:0];
    result    = cmd.incr ? incr_val : read_val;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_head;
    end
    if (exec_fire) begin
      rsp.op_echo     <= cmd.incr ? OP_INCR : OP_READ;
      rsp.object_echo <= cmd.object_id;
      rsp.version_out <= VER_W'(result);
    end
  end

  // counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (state == BK_CLEAR) begin
      table_mem[clr_idx] <= '0;
    end else if (exec_fire && cmd.incr && cmd.id_ok) begin
      table_mem[cmd.object_id[IDX_W-1:0]] <= incr_val;
    end
    if (q_pop) begin
      rd_data <= table_mem[q_head.object_id[IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the per-object modular version table
`timescale 1ns / 1ps

// The table is checked two ways. A short directed table comes first: empty
// table reads, the all-zero and all-one ids and references, increments and a
// full wrap of one counter. Rows whose result is obvious carry it typed in;
// the others are checked against the shadow table below. After the table
// come random requests, mostly aimed at a few hot objects so that counters
// wrap many times and reads see every distance. Both sides idle at random,
// and the receiver holds off once for a long stretch to back the block up.
module tb_top;
  import movt_pkg::*;

  localparam int OBJECT_COUNT  = 4096;
  localparam int VERSION_SLOTS = 16;
  localparam int RANDOM_ITEMS  = 1125;
  localparam int HOT_OBJECTS   = 8;
  // clearing pass plus the long receiver hold-off, many times over
  localparam int STALL_LIMIT   = 20000;
  localparam int DRAIN_CYCLES  = 16;
  localparam int HOLD_CYCLES   = 150;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    req_item_t        req;
    bit               pinned;   // expected version typed in below
    logic [VER_W-1:0] ver;
  } stim_row_t;

  logic      clk;
  logic      rst;
  logic      push;
  logic      full;
  req_item_t req;
  logic      empty;
  logic      pop;
  rsp_item_t rsp;

  modular_object_version_table_top #(
    .OBJECT_COUNT (OBJECT_COUNT),
    .VERSION_SLOTS(VERSION_SLOTS)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .empty(empty),
    .pop  (pop),
    .rsp  (rsp)
  );

  // shadow copy of the counter memory and results still owed by the block
  int unsigned shadow_versions [OBJECT_COUNT];
  rsp_item_t   pending_versions[$];
  stim_row_t   directed_rows[$];

  int n_sent;
  int n_incr;
  int n_checked;
  int n_errors;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // expected result of one request; an increment also updates the shadow
  function automatic rsp_item_t predict_version(input req_item_t r);
    rsp_item_t   res;
    bit          in_range;
    int unsigned cur;
    int unsigned nxt;
    int unsigned ref_mod;
    in_range = r.object_id < OBJECT_COUNT;
    cur = in_range ? shadow_versions[r.object_id] : 0;
    if (r.opcode == OP_INCR) begin
      nxt = (cur >= VERSION_SLOTS - 1) ? 0 : cur + 1;
      if (in_range)
        shadow_versions[r.object_id] = nxt;
    end else begin
      // reference is folded into the slot range before the subtraction
      ref_mod = r.ref_version % VERSION_SLOTS;
      nxt = (cur >= ref_mod) ? cur - ref_mod : cur + VERSION_SLOTS - ref_mod;
    end
    res.op_echo     = r.opcode;
    res.object_echo = r.object_id;
    res.version_out = nxt[VER_W-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic op, input logic [ID_W-1:0] id,
                                  input logic [VER_W-1:0] ref_ver, input bit pinned,
                                  input logic [VER_W-1:0] ver);
    stim_row_t row;
    row.req.opcode      = op;
    row.req.object_id   = id;
    row.req.ref_version = ref_ver;
    row.pinned          = pinned;
    row.ver             = ver;
    directed_rows.push_back(row);
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input req_item_t r, input bit pinned,
                           input logic [VER_W-1:0] pinned_ver, input bit may_idle);
    rsp_item_t want;
    while (may_idle && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    req  <= r;
    forever begin
      @(posedge clk);
      if (!full)
        break;
    end
    want = predict_version(r);
    if (pinned)
      want.version_out = pinned_ver;
    pending_versions.push_back(want);
    n_sent++;
    if (r.opcode == OP_INCR)
      n_incr++;
    @(negedge clk);
  endtask

  // result checker: every popped result against the oldest expectation
  always @(posedge clk) begin
    rsp_item_t want;
    bit        bad;
    if (!rst && pop && !empty) begin
      if (pending_versions.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected result: op %0d obj 0x%03h ver %0d",
                   rsp.op_echo, rsp.object_echo, rsp.version_out);
      end else begin
        want = pending_versions.pop_front();
        n_checked++;
        bad = (rsp.op_echo !== want.op_echo) || (rsp.object_echo !== want.object_echo) ||
              (rsp.version_out !== want.version_out);
        if (bad) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("result %0d: expected op %0d obj 0x%03h ver %0d, got op %0d obj 0x%03h ver %0d",
                     n_checked, want.op_echo, want.object_echo, want.version_out,
                     rsp.op_echo, rsp.object_echo, rsp.version_out);
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (!rst && ((push && !full) || (pop && !empty)))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d requests sent, %0d results checked",
               STALL_LIMIT, n_sent, n_checked);
      $display("modular_object_version_table_top: mismatch");
      $finish;
    end
  end

  // receiver: random pop gaps, a stretch without gaps, and one long hold-off
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && n_checked >= 300) begin
        // block backs up: two-entry queue and back end fill, full rises
        hold_done = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (n_checked >= 450 && n_checked < 650) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 9);
      end
    end
  end

  initial begin
    logic [ID_W-1:0] hot_ids[HOT_OBJECTS];
    req_item_t       r;
    rst  = 1'b1;
    push = 1'b0;
    req  = '0;
    n_sent = 0;
    n_incr = 0;
    n_checked = 0;
    n_errors = 0;
    stall_cycles = 0;
    for (int i = 0; i < OBJECT_COUNT; i++)
      shadow_versions[i] = 0;

    // freshly cleared table reads as zero, reference wraps the difference
    add_row(OP_READ, 12'h000, 4'h0, 1'b1, 4'h0);
    add_row(OP_READ, 12'hfff, 4'hf, 1'b1, 4'h1);
    add_row(OP_READ, 12'haaa, 4'h5, 1'b1, 4'hb);
    // first increments at both ends of the id range, reference ignored
    add_row(OP_INCR, 12'h000, 4'hf, 1'b1, 4'h1);
    add_row(OP_INCR, 12'hfff, 4'h0, 1'b1, 4'h1);
    add_row(OP_READ, 12'h000, 4'h1, 1'b1, 4'h0);
    add_row(OP_READ, 12'hfff, 4'h2, 1'b1, 4'hf);
    add_row(OP_INCR, 12'h555, 4'ha, 1'b1, 4'h1);
    add_row(OP_READ, 12'h555, 4'h1, 1'b1, 4'h0);
    // run the top counter up to the last slot, then wrap it back to zero
    for (int i = 0; i < VERSION_SLOTS - 2; i++)
      add_row(OP_INCR, 12'hfff, 4'($urandom_range(15)), 1'b0, 4'h0);
    add_row(OP_INCR, 12'hfff, 4'h3, 1'b1, 4'h0);
    add_row(OP_READ, 12'hfff, 4'h0, 1'b1, 4'h0);

    for (int i = 0; i < HOT_OBJECTS; i++)
      hot_ids[i] = ID_W'($urandom_range(OBJECT_COUNT - 1));

    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // full stays high through the clearing pass; send_item waits it out
    foreach (directed_rows[i])
      send_item(directed_rows[i].req, directed_rows[i].pinned, directed_rows[i].ver, 1'b1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 700) begin
        // let the block drain completely before carrying on
        while (pending_versions.size() != 0) begin
          push <= 1'b0;
          @(negedge clk);
        end
      end
      r.opcode      = $urandom_range(1) ? OP_INCR : OP_READ;
      // mostly a few hot objects so counters wrap, the rest anywhere
      r.object_id   = ($urandom_range(99) < 80) ? hot_ids[$urandom_range(HOT_OBJECTS - 1)]
                                                : ID_W'($urandom_range(OBJECT_COUNT - 1));
      r.ref_version = VER_W'($urandom_range(15));
      send_item(r, 1'b0, '0, !(i >= 400 && i < 600));
    end
    push <= 1'b0;

    while (pending_versions.size() != 0)
      @(posedge clk);
    // stray results would show up here
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d requests (%0d increments, %0d reads), %0d results checked",
             n_sent, n_incr, n_sent - n_incr, n_checked);
    $display("hot objects wrapped repeatedly, receiver backed up once, %0d errors", n_errors);
    if (n_errors == 0 && pending_versions.size() == 0)
      $display("modular_object_version_table_top: match");
    else
      $display("modular_object_version_table_top: mismatch");
    $finish;
  end

endmodule

FILE: files.f
design/movt_pkg.sv
design/movt_front.sv
design/movt_queue.sv
design/movt_back.sv
design/modular_object_version_table_top.sv
dv/tb_top.sv
